>>> src/bpg_pkg.sv
// Shared types, format codes and helper functions for the bitmap-to-gray block.
// No dependencies; bpg_if, bpg_assembler, bpg_gray and the top level use this package.
`timescale 1ns / 1ps

package bpg_pkg;

  // Widths fixed by the register and field definitions
  localparam int unsigned ColW     = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned SumW     = 10;

  // Division by three as multiply by reciprocal, exact for sums up to 765
  localparam int unsigned DivThreeMul   = 683;
  localparam int unsigned DivThreeShift = 11;
  localparam int unsigned ProdW         = 20;

  typedef logic [2:0] fmt_t;

  localparam fmt_t FmtRgb565 = 3'd0;
  localparam fmt_t FmtRgb555 = 3'd1;
  localparam fmt_t Fmt24     = 3'd2;
  localparam fmt_t Fmt32     = 3'd3;
  localparam fmt_t FmtPal    = 3'd4;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgPixelFormat = 2'd0;
  localparam cfg_idx_t CfgRowWidth    = 2'd1;

  // One completed pixel handed from the byte assembler to the gray stage
  typedef struct packed {
    logic              valid;
    fmt_t              fmt;
    logic [ColorW-1:0] gather;
    logic              row_end;
    logic              pal_oob;
  } pixel_t;

  function automatic logic [2:0] bytes_per_pixel(fmt_t f);
    logic [2:0] n;
    case (f)
      FmtRgb565: n = 3'd2;
      FmtRgb555: n = 3'd2;
      Fmt32:     n = 3'd4;
      FmtPal:    n = 3'd1;
      default:   n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic [SumW-1:0] sum3(logic [ColorW-1:0] c);
    return SumW'(c[7:0]) + SumW'(c[15:8]) + SumW'(c[23:16]);
  endfunction

endpackage

>>> src/bpg_if.sv
// Channel interfaces of the bitmap-to-gray block: stream input, result output,
// configuration write. Depends on bpg_pkg.
`timescale 1ns / 1ps

interface bpg_stream_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  stream_byte;
  logic [7:0]  palette_slot;
  logic [23:0] palette_color;

  modport source (output valid, action, stream_byte, palette_slot, palette_color,
                  input ready);
  modport sink   (input valid, action, stream_byte, palette_slot, palette_color,
                  output ready);
endinterface

interface bpg_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray;
  logic       row_end;

  modport source (output valid, gray, row_end, input ready);
  modport sink   (input valid, gray, row_end, output ready);
endinterface

interface bpg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpg_pkg::CfgIdxW-1:0]   index;
  logic [bpg_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/bpg_palette.sv
// Palette memory: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bpg_palette #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [23:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [23:0]   rd_data_o
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data_q;

  // Write a palette entry, read one entry per pixel lookup
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/bpg_assembler.sv
// Byte assembler: config registers, pixel gathering, column and pad tracking,
// palette read issue. Depends on bpg_pkg and bpg_cfg_if.
`timescale 1ns / 1ps

module bpg_assembler #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned AW            = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bpg_cfg_if.sink          cfg_i,
  input  logic             accept_i,
  input  logic             action_i,
  input  logic [7:0]       stream_byte_i,
  output bpg_pkg::pixel_t  px_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o
);

  bpg_pkg::fmt_t              fmt_q;
  logic [bpg_pkg::ColW-1:0]   width_q;
  logic [23:0]                gather_q, gather_d;
  logic [1:0]                 phase_q, phase_d;
  logic [bpg_pkg::ColW-1:0]   col_q, col_d;
  logic [1:0]                 pad_q, pad_d;

  bpg_pkg::fmt_t              fmt;
  logic [2:0]                 bpp;
  logic [1:0]                 last;
  logic [bpg_pkg::ColW-1:0]   eff_w;
  logic [1:0]                 row_bytes_lo;

  assign cfg_i.ready = 1'b1;

  // Resolve format and width to their effective values
  always_comb begin
    fmt  = (fmt_q <= bpg_pkg::FmtPal) ? fmt_q : bpg_pkg::Fmt24;
    bpp  = bpg_pkg::bytes_per_pixel(fmt);
    last = 2'(bpp - 3'd1);
    if (width_q == '0) begin
      eff_w = bpg_pkg::ColW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = bpg_pkg::ColW'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    row_bytes_lo = 2'(eff_w[1:0] * bpp[1:0]);
  end

  // Gather bytes, drop padding, advance column on each finished pixel
  always_comb begin
    gather_d = gather_q;
    phase_d  = phase_q;
    col_d    = col_q;
    pad_d    = pad_q;
    px_o     = '0;
    if (accept_i && action_i) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else begin
        case (phase_q)
          2'd0:    gather_d[7:0]   = stream_byte_i;
          2'd1:    gather_d[15:8]  = stream_byte_i;
          2'd2:    gather_d[23:16] = stream_byte_i;
          default: gather_d        = gather_q;
        endcase
        if (phase_q < last) begin
          phase_d = phase_q + 2'd1;
        end else begin
          phase_d     = 2'd0;
          px_o.valid  = 1'b1;
          px_o.fmt    = fmt;
          px_o.gather = gather_d;
          if (({1'b0, col_q} + 14'd1) >= {1'b0, eff_w}) begin
            px_o.row_end = 1'b1;
            col_d        = '0;
            pad_d        = 2'd0 - row_bytes_lo;
          end else begin
            col_d = col_q + bpg_pkg::ColW'(1);
          end
        end
      end
    end
    px_o.pal_oob = px_o.valid && (fmt == bpg_pkg::FmtPal) &&
                   ({1'b0, gather_d[7:0]} >= 9'(PALETTE_DEPTH));
  end

  // Issue the palette read on a finished index pixel whose index is inside the palette
  assign rd_en_o   = px_o.valid && (px_o.fmt == bpg_pkg::FmtPal) && !px_o.pal_oob;
  assign rd_addr_o = gather_d[AW-1:0];

  // Hold config registers and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= bpg_pkg::Fmt24;
      width_q  <= bpg_pkg::ColW'(1);
      gather_q <= '0;
      phase_q  <= '0;
      col_q    <= '0;
      pad_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          bpg_pkg::CfgPixelFormat: fmt_q   <= cfg_i.data[2:0];
          bpg_pkg::CfgRowWidth:    width_q <= cfg_i.data;
          default:                 fmt_q   <= fmt_q;
        endcase
      end
      gather_q <= gather_d;
      phase_q  <= phase_d;
      col_q    <= col_d;
      pad_q    <= pad_d;
    end
  end

  // Padding only starts after a pixel has closed
  a_pad_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_q != 2'd0) |-> (phase_q == 2'd0))
    else $error("padding pending with a partial pixel");

  a_px_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_o.valid |-> (accept_i && action_i))
    else $error("pixel finished without a stream beat");

  a_rd_pal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> (px_o.valid && px_o.fmt == bpg_pkg::FmtPal))
    else $error("palette read outside an index pixel");

endmodule

>>> src/bpg_gray.sv
// Gray stage: holds a pixel beside its palette data, averages the channels and
// registers the result. Depends on bpg_pkg and bpg_result_if.
`timescale 1ns / 1ps

module bpg_gray (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bpg_pkg::pixel_t px_i,
  input  logic [23:0]     pal_data_i,
  output logic            ready_o,
  bpg_result_if.source    out_o
);

  logic                       s1_v_q;
  bpg_pkg::pixel_t            s1_q;
  logic                       out_v_q;
  logic [7:0]                 gray_q;
  logic                       row_end_q;
  logic                       out_load;
  logic [bpg_pkg::SumW-1:0]   sum;
  logic [bpg_pkg::ProdW-1:0]  prod;

  assign out_load = s1_v_q && (!out_v_q || out_o.ready);
  assign ready_o  = !s1_v_q || out_load;

  // Scale channels per format and add them
  always_comb begin
    case (s1_q.fmt)
      bpg_pkg::FmtRgb565: sum = {2'b0, s1_q.gather[4:0], 3'b0}
                              + {2'b0, s1_q.gather[10:5], 2'b0}
                              + {2'b0, s1_q.gather[15:11], 3'b0};
      bpg_pkg::FmtRgb555: sum = {2'b0, s1_q.gather[4:0], 3'b0}
                              + {2'b0, s1_q.gather[9:5], 3'b0}
                              + {2'b0, s1_q.gather[14:10], 3'b0};
      bpg_pkg::FmtPal:    sum = s1_q.pal_oob ? '0 : bpg_pkg::sum3(pal_data_i);
      default:            sum = bpg_pkg::sum3(s1_q.gather);
    endcase
    prod = bpg_pkg::ProdW'(sum) * bpg_pkg::ProdW'(bpg_pkg::DivThreeMul);
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s1_v_q <= px_i.valid;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Load payloads
  always_ff @(posedge clk_i) begin
    if (ready_o && px_i.valid) begin
      s1_q <= px_i;
    end
    if (out_load) begin
      gray_q    <= prod[bpg_pkg::DivThreeShift +: 8];
      row_end_q <= s1_q.row_end;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.gray    = gray_q;
  assign out_o.row_end = row_end_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_load) |=> s1_v_q)
    else $error("pending pixel dropped");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s1_v_q))
    else $error("result beat without a pixel");

  a_stall_why: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (out_v_q && !out_o.ready && s1_v_q))
    else $error("input stalled without output backpressure");

endmodule

>>> src/bmp_pixel_to_gray.sv
// Top level of the bitmap-to-gray converter: byte assembler, palette memory,
// gray stage. Depends on bpg_pkg, bpg_if, bpg_assembler, bpg_palette, bpg_gray.
`timescale 1ns / 1ps
//
//  Channel  | Dir | Beat contents
//  ---------+-----+------------------------------------------------------------
//  cfg_i    | in  | index (0 pixel_format, 1 row_width), data
//  in_i     | in  | action, stream_byte, palette_slot, palette_color
//  out_o    | out | gray, row_end (one beat per completed pixel)
//
//  One input beat per cycle while in_i.ready is high; the edge that accepts a
//  pixel's last byte loads the pixel register and the palette read together,
//  and the averaged gray is loaded into the output register for out_o once that register is free.
//  Reset clears the stream state and sets 24-bit format, row width 1; the
//  palette holds garbage until written, and no clearing pass runs.
//  A stalled output fills the gray stage, then in_i.ready drops; config writes
//  are always taken.

module bmp_pixel_to_gray #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpg_cfg_if.sink       cfg_i,
  bpg_stream_if.sink    in_i,
  bpg_result_if.source  out_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  bpg_pkg::pixel_t px;
  logic            accept;
  logic            wr_en;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [23:0]     rd_data;
  logic            ready;

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;
  assign wr_en      = accept && !in_i.action &&
                      ({1'b0, in_i.palette_slot} < 9'(PALETTE_DEPTH));

  bpg_assembler #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .AW            (AW)
  ) u_asm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .accept_i      (accept),
    .action_i      (in_i.action),
    .stream_byte_i (in_i.stream_byte),
    .px_o          (px),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr)
  );

  bpg_palette #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_pal (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (in_i.palette_slot[AW-1:0]),
    .wr_data_i (in_i.palette_color),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bpg_gray u_gray (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .px_i       (px),
    .pal_data_i (rd_data),
    .ready_o    (ready),
    .out_o      (out_o)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for bmp_pixel_to_gray: random byte streams in all pixel
// formats, palette loads and register changes, checked beat by beat against a predictor.
// Depends on bpg_pkg, the bpg channel interfaces and the bmp_pixel_to_gray RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MaxWidth     = 4096;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned StreamItems  = 1000;

  localparam logic              ActPalette = 1'b0;
  localparam logic              ActPixel   = 1'b1;
  localparam bpg_pkg::cfg_idx_t CfgSpare   = 2'd2;

  typedef struct packed {
    logic        action;
    logic [7:0]  stream_byte;
    logic [7:0]  palette_slot;
    logic [23:0] palette_color;
  } stream_beat_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       row_end;
  } gray_beat_t;

  // Register copy plus pixel assembly state
  typedef struct packed {
    bpg_pkg::fmt_t fmt;
    logic [12:0]   width;
    logic [23:0]   gather;
    logic [1:0]    phase;
    logic [12:0]   column;
    logic [1:0]    pad;
  } pixel_state_t;

  logic clk_i;
  logic rst_ni;

  bpg_cfg_if    cfg_if ();
  bpg_stream_if stream_if ();
  bpg_result_if result_if ();

  bmp_pixel_to_gray dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (stream_if),
    .out_o  (result_if)
  );

  stream_beat_t pending_beats[$];
  gray_beat_t   expected_grays[$];

  pixel_state_t gray_state;     // advanced on accepted beats
  pixel_state_t plan_state;     // advanced while stimulus is planned
  logic [23:0]  palette_mirror [256];
  bit           palette_loaded [256];

  int unsigned planned_beats;
  int unsigned accepted_beats;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned hold_requests;
  int unsigned holds_served;

  // Feed one stream byte through the assembler; return 1 when a pixel completes
  function automatic bit take_stream_byte(inout pixel_state_t st, input logic [7:0] b,
                                          output bpg_pkg::fmt_t f, output logic [23:0] pix,
                                          output logic row_end);
    int unsigned bpp;
    int unsigned w;
    int unsigned row_bytes;
    f       = (st.fmt <= bpg_pkg::FmtPal) ? st.fmt : bpg_pkg::Fmt24;
    pix     = '0;
    row_end = 1'b0;
    if (st.pad != 2'd0) begin
      st.pad = st.pad - 2'd1;
      return 1'b0;
    end
    case (f)
      bpg_pkg::FmtRgb565, bpg_pkg::FmtRgb555: bpp = 2;
      bpg_pkg::Fmt32:                         bpp = 4;
      bpg_pkg::FmtPal:                        bpp = 1;
      default:                                bpp = 3;
    endcase
    if (st.phase < 2'd3) st.gather[8*st.phase +: 8] = b;
    if (st.phase < bpp - 1) begin
      st.phase = st.phase + 2'd1;
      return 1'b0;
    end
    st.phase = 2'd0;
    pix      = st.gather;
    if (st.width == 13'd0) w = 1;
    else if (st.width > MaxWidth) w = MaxWidth;
    else w = st.width;
    if (st.column + 1 >= w) begin
      row_end   = 1'b1;
      st.column = '0;
      row_bytes = w * bpp;
      st.pad    = 2'((4 - row_bytes % 4) % 4);
    end else begin
      st.column = st.column + 13'd1;
    end
    return 1'b1;
  endfunction

  // Average of the three scaled channels of a completed pixel
  function automatic logic [7:0] gray_of(bpg_pkg::fmt_t f, logic [23:0] pix);
    logic [9:0]  total;
    logic [23:0] color;
    case (f)
      bpg_pkg::FmtRgb565: total = {2'b0, pix[4:0], 3'b0} + {2'b0, pix[10:5], 2'b0}
                                + {2'b0, pix[15:11], 3'b0};
      bpg_pkg::FmtRgb555: total = {2'b0, pix[4:0], 3'b0} + {2'b0, pix[9:5], 3'b0}
                                + {2'b0, pix[14:10], 3'b0};
      bpg_pkg::FmtPal: begin
        color = palette_mirror[pix[7:0]];
        total = 10'(color[7:0]) + 10'(color[15:8]) + 10'(color[23:16]);
      end
      default: total = 10'(pix[7:0]) + 10'(pix[15:8]) + 10'(pix[23:16]);
    endcase
    return 8'(total / 10'd3);
  endfunction

  function automatic void plan_palette_write(logic [7:0] slot, logic [23:0] color);
    stream_beat_t bt;
    bt.action        = ActPalette;
    bt.stream_byte   = 8'($urandom);
    bt.palette_slot  = slot;
    bt.palette_color = color;
    pending_beats.push_back(bt);
    palette_loaded[slot] = 1'b1;
    planned_beats++;
  endfunction

  // Queue a stream byte; load the palette entry first if this byte would read an empty one
  function automatic void plan_stream_byte(logic [7:0] b);
    pixel_state_t  trial;
    bpg_pkg::fmt_t f;
    logic [23:0]   pix;
    logic          end_flag;
    stream_beat_t  bt;
    trial = plan_state;
    if (take_stream_byte(trial, b, f, pix, end_flag) && f == bpg_pkg::FmtPal &&
        !palette_loaded[pix[7:0]])
      plan_palette_write(pix[7:0], 24'($urandom));
    plan_state       = trial;
    bt.action        = ActPixel;
    bt.stream_byte   = b;
    bt.palette_slot  = 8'($urandom);
    bt.palette_color = 24'($urandom);
    pending_beats.push_back(bt);
    planned_beats++;
  endfunction

  // Hold until every planned beat is taken and every gray has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (accepted_beats != planned_beats || expected_grays.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(bpg_pkg::cfg_idx_t idx, logic [12:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == bpg_pkg::CfgPixelFormat) begin
      gray_state.fmt = data[2:0];
      plan_state.fmt = data[2:0];
    end else if (idx == bpg_pkg::CfgRowWidth) begin
      gray_state.width = data;
      plan_state.width = data;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run the cycle budget
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("bmp_pixel_to_gray regression: fail");
      $finish;
    end
  end

  // Driver: bursts of random length separated by random gaps
  int unsigned  burst_left;
  int unsigned  send_gap;
  stream_beat_t next_beat;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stream_if.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      send_gap   = 0;
    end else if (!stream_if.valid || stream_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        stream_if.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        stream_if.valid         <= 1'b1;
        stream_if.action        <= next_beat.action;
        stream_if.stream_byte   <= next_beat.stream_byte;
        stream_if.palette_slot  <= next_beat.palette_slot;
        stream_if.palette_color <= next_beat.palette_color;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          send_gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        stream_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall rate changes every so often; long hold when requested
  int unsigned mode_left;
  int unsigned stall_pct;
  int unsigned hold_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      mode_left = 0;
      hold_left = 0;
    end else begin
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HoldCycles;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(3))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor: check gray beats, then predict from accepted stream beats
  gray_beat_t    want;
  bpg_pkg::fmt_t done_fmt;
  logic [23:0]   done_pix;
  logic          done_end;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        if (expected_grays.size() == 0) begin
          $error("unexpected beat: gray %0d row_end %0b", result_if.gray, result_if.row_end);
          mismatches++;
        end else begin
          want = expected_grays.pop_front();
          if (result_if.gray !== want.gray) begin
            $error("gray: expected %0d, got %0d", want.gray, result_if.gray);
            mismatches++;
          end
          if (result_if.row_end !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, result_if.row_end);
            mismatches++;
          end
        end
      end
      if (stream_if.valid && stream_if.ready) begin
        if (stream_if.action == ActPalette) begin
          palette_mirror[stream_if.palette_slot] = stream_if.palette_color;
        end else if (take_stream_byte(gray_state, stream_if.stream_byte, done_fmt,
                                      done_pix, done_end)) begin
          want.gray    = gray_of(done_fmt, done_pix);
          want.row_end = done_end;
          expected_grays.push_back(want);
        end
        accepted_beats++;
      end
    end
  end

  // Stimulus: directed extremes, then random phases with register changes between
  initial begin
    int unsigned   phase_no;
    int unsigned   n;
    int unsigned   k;
    int unsigned   r;
    bpg_pkg::fmt_t fmt_pick;
    logic [12:0]   width_pick;
    logic [9:0]    junk;

    cfg_if.valid            = 1'b0;
    cfg_if.index            = '0;
    cfg_if.data             = '0;
    stream_if.valid         = 1'b0;
    stream_if.action        = ActPixel;
    stream_if.stream_byte   = '0;
    stream_if.palette_slot  = '0;
    stream_if.palette_color = '0;
    result_if.ready         = 1'b0;
    gray_state              = '0;
    gray_state.fmt          = bpg_pkg::Fmt24;
    gray_state.width        = 13'd1;
    plan_state              = gray_state;
    foreach (palette_loaded[i]) palette_loaded[i] = 1'b0;

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset setting: 24-bit, one pixel per row, one pad byte; palette write inside a pixel
    plan_palette_write(8'h00, 24'h000000);
    plan_palette_write(8'hFF, 24'hFFFFFF);
    plan_stream_byte(8'hFF);
    plan_palette_write(8'h5A, 24'hA5C3E1);
    plan_stream_byte(8'hFF);
    plan_stream_byte(8'hFF);
    plan_stream_byte(8'h00);
    wait_idle();

    // RGB565 at full scale, two pad bytes
    write_register(bpg_pkg::CfgPixelFormat, 13'(bpg_pkg::FmtRgb565));
    plan_stream_byte(8'hFF);
    plan_stream_byte(8'hFF);
    plan_stream_byte(8'hAA);
    plan_stream_byte(8'h55);
    wait_idle();

    // RGB555 with only the unused bit set
    write_register(bpg_pkg::CfgPixelFormat, 13'(bpg_pkg::FmtRgb555));
    plan_stream_byte(8'h00);
    plan_stream_byte(8'h80);
    plan_stream_byte(8'hFF);
    plan_stream_byte(8'hFF);
    wait_idle();

    // 32-bit with only the unused byte set
    write_register(bpg_pkg::CfgPixelFormat, 13'(bpg_pkg::Fmt32));
    plan_stream_byte(8'h00);
    plan_stream_byte(8'h00);
    plan_stream_byte(8'h00);
    plan_stream_byte(8'hFF);
    wait_idle();

    // Palette index, three pixels per row, one pad byte
    write_register(bpg_pkg::CfgPixelFormat, 13'(bpg_pkg::FmtPal));
    write_register(bpg_pkg::CfgRowWidth, 13'd3);
    plan_stream_byte(8'h00);
    plan_stream_byte(8'hFF);
    plan_stream_byte(8'h5A);
    plan_stream_byte(8'h00);
    wait_idle();

    // Unused format code and zero row width; spare register index
    write_register(CfgSpare, 13'h1FFF);
    write_register(bpg_pkg::CfgPixelFormat, 13'd7);
    write_register(bpg_pkg::CfgRowWidth, 13'd0);
    plan_stream_byte(8'h10);
    plan_stream_byte(8'h20);
    plan_stream_byte(8'h30);
    plan_stream_byte(8'hFF);
    wait_idle();

    // Random phases; stream state carries over each register change
    phase_no = 0;
    while (planned_beats < StreamItems) begin
      r = $urandom_range(3);
      if (r != 1) begin
        fmt_pick = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        junk     = ($urandom_range(3) == 0) ? 10'($urandom) : 10'd0;
        write_register(bpg_pkg::CfgPixelFormat, {junk, fmt_pick});
      end
      if (r != 0) begin
        k = $urandom_range(99);
        if (k < 55) width_pick = 13'($urandom_range(1, 8));
        else if (k < 80) width_pick = 13'($urandom_range(9, 40));
        else if (k < 88) width_pick = 13'd0;
        else if (k < 94) width_pick = ($urandom_range(1) == 0) ? 13'(MaxWidth) : 13'h1FFF;
        else width_pick = 13'($urandom_range(100, 400));
        write_register(bpg_pkg::CfgRowWidth, width_pick);
      end

      n = $urandom_range(40, 120);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(99) < 15) begin
          plan_palette_write(8'($urandom), 24'($urandom));
        end else begin
          plan_stream_byte(8'($urandom));
        end
      end
      // Stall the result side long enough to back up the input
      if (phase_no % 4 == 2) hold_requests++;
      phase_no++;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("bmp_pixel_to_gray regression: pass");
    end else begin
      $display("bmp_pixel_to_gray regression: fail");
    end
    $finish;
  end

endmodule
